FILE: design/sgdc_pkg.sv
`default_nettype none

package sgdc_pkg;

    localparam int KIND_W  = 1;
    localparam int YEAR_IN_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int YEAR_OUT_W = 16;
    localparam int DOY_W   = 9;
    localparam int ACC_W   = 10;
    localparam int PC_W    = 5;

    localparam int NEW_YEAR_DAY   = 81;
    localparam int SAKA_OFFSET    = 78;
    localparam int YEAR_DAYS      = 365;
    localparam int LEAP_YEAR_DAYS = 366;
    localparam int LONG_MONTH     = 31;
    localparam int SHORT_MONTH    = 30;
    localparam int LAST_MONTH     = 11;
    localparam int LAST_SAKA_LONG = 5;

    // 400 keeps the biased year positive and the leap pattern unchanged
    localparam int LEAP_BIAS = 400;
    // divisibility by 25: multiply by the inverse mod 2^16, compare with limit
    localparam logic [15:0] INV25       = 16'd23593;
    localparam logic [15:0] DIV25_LIMIT = 16'd2621;

    typedef logic [PC_W-1:0] step_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_INIT_G,
        OP_INIT_S,
        OP_ADD_GLEN,
        OP_ADD_SLEN,
        OP_SUB_GLEN,
        OP_SUB_SLEN,
        OP_SUB_NY,
        OP_PREV_YEAR,
        OP_ADD_YDAYS,
        OP_WRAP,
        OP_MARK_S,
        OP_MARK_G,
        OP_DONE_S,
        OP_DONE_G,
        OP_REJECT
    } op_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_BAD,
        C_KIND1,
        C_IDX_EQ_MON,
        C_ACC_LT_NY,
        C_ACC_LE_YD,
        C_S_STOP,
        C_G_STOP
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        logic  gate;
        logic  hold;
        step_t target;
    } ctrl_t;

    localparam step_t PC_ENTRY       = 5'd0;
    localparam step_t PC_G_INIT      = 5'd1;
    localparam step_t PC_G_WAIT      = 5'd2;
    localparam step_t PC_G_SUM       = 5'd3;
    localparam step_t PC_G_SPLIT     = 5'd4;
    localparam step_t PC_S_MARK      = 5'd5;
    localparam step_t PC_S_WALK      = 5'd6;
    localparam step_t PC_S_DONE      = 5'd7;
    localparam step_t PC_G_PREV      = 5'd8;
    localparam step_t PC_G_PREV_WAIT = 5'd9;
    localparam step_t PC_G_REBASE    = 5'd10;
    localparam step_t PC_S_INIT      = 5'd11;
    localparam step_t PC_S_WAIT      = 5'd12;
    localparam step_t PC_S_SUM       = 5'd13;
    localparam step_t PC_S_WRAP      = 5'd14;
    localparam step_t PC_S_WRAP_WAIT = 5'd15;
    localparam step_t PC_G_MARK      = 5'd16;
    localparam step_t PC_G_WALK      = 5'd17;
    localparam step_t PC_G_DONE      = 5'd18;
    localparam step_t PC_REJECT      = 5'd19;

    function automatic ctrl_t mk(input op_t op, input cond_t cond, input logic gate,
                                 input logic hold, input step_t target);
        ctrl_t c;
        c.op     = op;
        c.cond   = cond;
        c.gate   = gate;
        c.hold   = hold;
        c.target = target;
        return c;
    endfunction

    // jump on cond to target, else stay (hold) or advance; a gated op is dropped on jump
    function automatic ctrl_t ucode(input step_t pc);
        ctrl_t c;
        unique case (pc)
            PC_ENTRY:       c = mk(OP_NOP,       C_BAD,        1'b1, 1'b0, PC_REJECT);
            PC_G_INIT:      c = mk(OP_INIT_G,    C_KIND1,      1'b1, 1'b0, PC_S_INIT);
            PC_G_WAIT:      c = mk(OP_NOP,       C_NEVER,      1'b0, 1'b0, PC_ENTRY);
            PC_G_SUM:       c = mk(OP_ADD_GLEN,  C_IDX_EQ_MON, 1'b1, 1'b1, PC_G_SPLIT);
            PC_G_SPLIT:     c = mk(OP_SUB_NY,    C_ACC_LT_NY,  1'b1, 1'b0, PC_G_PREV);
            PC_S_MARK:      c = mk(OP_MARK_S,    C_NEVER,      1'b0, 1'b0, PC_ENTRY);
            PC_S_WALK:      c = mk(OP_SUB_SLEN,  C_S_STOP,     1'b1, 1'b1, PC_S_DONE);
            PC_S_DONE:      c = mk(OP_DONE_S,    C_NEVER,      1'b0, 1'b0, PC_ENTRY);
            PC_G_PREV:      c = mk(OP_PREV_YEAR, C_NEVER,      1'b0, 1'b0, PC_ENTRY);
            PC_G_PREV_WAIT: c = mk(OP_NOP,       C_NEVER,      1'b0, 1'b0, PC_ENTRY);
            PC_G_REBASE:    c = mk(OP_ADD_YDAYS, C_ALWAYS,     1'b0, 1'b0, PC_S_MARK);
            PC_S_INIT:      c = mk(OP_INIT_S,    C_NEVER,      1'b0, 1'b0, PC_ENTRY);
            PC_S_WAIT:      c = mk(OP_NOP,       C_NEVER,      1'b0, 1'b0, PC_ENTRY);
            PC_S_SUM:       c = mk(OP_ADD_SLEN,  C_IDX_EQ_MON, 1'b1, 1'b1, PC_S_WRAP);
            PC_S_WRAP:      c = mk(OP_WRAP,      C_ACC_LE_YD,  1'b1, 1'b0, PC_G_MARK);
            PC_S_WRAP_WAIT: c = mk(OP_NOP,       C_NEVER,      1'b0, 1'b0, PC_ENTRY);
            PC_G_MARK:      c = mk(OP_MARK_G,    C_NEVER,      1'b0, 1'b0, PC_ENTRY);
            PC_G_WALK:      c = mk(OP_SUB_GLEN,  C_G_STOP,     1'b1, 1'b1, PC_G_DONE);
            PC_G_DONE:      c = mk(OP_DONE_G,    C_NEVER,      1'b0, 1'b0, PC_ENTRY);
            PC_REJECT:      c = mk(OP_REJECT,    C_NEVER,      1'b0, 1'b0, PC_ENTRY);
            default:        c = mk(OP_NOP,       C_ALWAYS,     1'b0, 1'b0, PC_REJECT);
        endcase
        return c;
    endfunction

    function automatic logic [DAY_W-1:0] greg_month_days(input logic [MONTH_W-1:0] m,
                                                         input logic leap);
        logic [DAY_W-1:0] n;
        unique case (m)
            4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: n = DAY_W'(LONG_MONTH);
            4'd3, 4'd5, 4'd8, 4'd10:                    n = DAY_W'(SHORT_MONTH);
            4'd1:    n = leap ? 5'd29 : 5'd28;
            default: n = '0;
        endcase
        return n;
    endfunction

    function automatic logic [DAY_W-1:0] saka_month_days(input logic [MONTH_W-1:0] m,
                                                         input logic leap);
        logic [DAY_W-1:0] n;
        if (m == '0)
        begin
            n = leap ? DAY_W'(LONG_MONTH) : DAY_W'(SHORT_MONTH);
        end
        else if (m <= MONTH_W'(LAST_SAKA_LONG))
        begin
            n = DAY_W'(LONG_MONTH);
        end
        else
        begin
            n = DAY_W'(SHORT_MONTH);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

FILE: design/sgdc_query_if.sv
`default_nettype none

interface sgdc_query_if;
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic [sgdc_pkg::YEAR_IN_W-1:0]  year_in;
    logic [sgdc_pkg::MONTH_W-1:0]    month_in;
    logic [sgdc_pkg::DAY_W-1:0]      day_in;

    modport source (output valid, kind, year_in, month_in, day_in, input ready);
    modport sink   (input valid, kind, year_in, month_in, day_in, output ready);
endinterface

`default_nettype wire

FILE: design/sgdc_answer_if.sv
`default_nettype none

interface sgdc_answer_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [sgdc_pkg::YEAR_OUT_W-1:0] year_out;
    logic [sgdc_pkg::MONTH_W-1:0]          month_out;
    logic [sgdc_pkg::DAY_W-1:0]            day_out;
    logic [sgdc_pkg::DOY_W-1:0]            day_of_year_out;
    logic                                  error;

    modport source (output valid, year_out, month_out, day_out, day_of_year_out, error,
                    input ready);
    modport sink   (input valid, year_out, month_out, day_out, day_of_year_out, error,
                    output ready);
endinterface

`default_nettype wire

FILE: design/sgdc_leap.sv
`default_nettype none

module sgdc_leap (
    input  wire logic                                  clk,
    input  wire logic signed [sgdc_pkg::YEAR_OUT_W-1:0] year,
    output logic                                       leap
);

    logic [15:0] biased;
    logic [15:0] prod;
    logic        div4;
    logic        div16;
    logic        div25;
    logic        leap_next;
    logic        leap_reg;

    assign biased    = unsigned'(year) + 16'(sgdc_pkg::LEAP_BIAS);
    assign prod      = biased * sgdc_pkg::INV25;
    assign div4      = (biased[1:0] == 2'b00);
    assign div16     = (biased[3:0] == 4'b0000);
    assign div25     = (prod <= sgdc_pkg::DIV25_LIMIT);
    assign leap_next = div4 && (!div25 || div16);

    always_ff @(posedge clk)
    begin
        leap_reg <= leap_next;
    end

    assign leap = leap_reg;

endmodule

`default_nettype wire

FILE: design/saka_gregorian_date_converter_core.sv
`default_nettype none

// Converts one date per transaction between the Gregorian and Indian national
// (Saka) calendars; kind 0 goes Gregorian to Saka, kind 1 Saka to Gregorian.
// A small microcode ROM steps a single accumulator through the month lengths,
// one month per cycle, so the time from accept to result depends on the data:
// it grows with month_in and the result month; in kind 0 a date before
// Chaitra 1 also passes the previous-year, wait and rebase steps, in kind 1 a
// year wrap adds a wait step, and a rejected date goes straight to the reject
// step. One date is in flight at a time; a new transaction is taken as soon
// as the previous result sits in the output register. The leap flag is
// registered, so every change of year costs one wait step.
module saka_gregorian_date_converter_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    sgdc_query_if.sink          query,
    sgdc_answer_if.source       answer
);

    localparam logic signed [sgdc_pkg::ACC_W-1:0] NY =
        sgdc_pkg::ACC_W'(sgdc_pkg::NEW_YEAR_DAY);

    sgdc_pkg::state_t state_reg, state_next;
    sgdc_pkg::step_t  pc_reg, pc_next;
    sgdc_pkg::ctrl_t  ctrl;

    logic                                  kind_reg, kind_next;
    logic [sgdc_pkg::YEAR_IN_W-1:0]        year_reg, year_next;
    logic [sgdc_pkg::MONTH_W-1:0]          month_reg, month_next;
    logic [sgdc_pkg::DAY_W-1:0]            day_reg, day_next;

    logic signed [sgdc_pkg::ACC_W-1:0]      acc_reg, acc_next;
    logic [sgdc_pkg::MONTH_W-1:0]          idx_reg, idx_next;
    logic signed [sgdc_pkg::YEAR_OUT_W-1:0] ry_reg, ry_next;
    logic signed [sgdc_pkg::YEAR_OUT_W-1:0] lyear_reg, lyear_next;
    logic [sgdc_pkg::DOY_W-1:0]            doy_reg, doy_next;

    logic                                  out_valid_reg, out_valid_next;
    logic signed [sgdc_pkg::YEAR_OUT_W-1:0] oyear_reg, oyear_next;
    logic [sgdc_pkg::MONTH_W-1:0]          omonth_reg, omonth_next;
    logic [sgdc_pkg::DAY_W-1:0]            oday_reg, oday_next;
    logic [sgdc_pkg::DOY_W-1:0]            odoy_reg, odoy_next;
    logic                                  oerr_reg, oerr_next;

    logic                                  leap;
    logic [sgdc_pkg::DAY_W-1:0]            len_g;
    logic [sgdc_pkg::DAY_W-1:0]            len_s;
    logic signed [sgdc_pkg::ACC_W-1:0]      len_g_x;
    logic signed [sgdc_pkg::ACC_W-1:0]      len_s_x;
    logic [sgdc_pkg::DOY_W-1:0]            ydays;
    logic signed [sgdc_pkg::ACC_W-1:0]      ydays_x;
    logic signed [sgdc_pkg::ACC_W-1:0]      acc_inc;
    logic                                  g_fit;
    logic                                  cond_hit;
    logic                                  exec;
    logic                                  finish;
    logic                                  stall;

    sgdc_leap u_leap (
        .clk  (clk),
        .year (lyear_reg),
        .leap (leap)
    );

    assign len_g   = sgdc_pkg::greg_month_days(idx_reg, leap);
    assign len_s   = sgdc_pkg::saka_month_days(idx_reg, leap);
    assign len_g_x = signed'({5'b0, len_g});
    assign len_s_x = signed'({5'b0, len_s});
    assign ydays   = leap ? sgdc_pkg::DOY_W'(sgdc_pkg::LEAP_YEAR_DAYS)
                          : sgdc_pkg::DOY_W'(sgdc_pkg::YEAR_DAYS);
    assign ydays_x = signed'({1'b0, ydays});
    assign acc_inc = acc_reg + 10'sd1;
    assign g_fit   = (acc_reg <= len_g_x);
    assign ctrl    = sgdc_pkg::ucode(pc_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            sgdc_pkg::C_NEVER:      cond_hit = 1'b0;
            sgdc_pkg::C_ALWAYS:     cond_hit = 1'b1;
            sgdc_pkg::C_BAD:        cond_hit = (month_reg > 4'(sgdc_pkg::LAST_MONTH))
                                               || (day_reg == '0);
            sgdc_pkg::C_KIND1:      cond_hit = kind_reg;
            sgdc_pkg::C_IDX_EQ_MON: cond_hit = (idx_reg == month_reg);
            sgdc_pkg::C_ACC_LT_NY:  cond_hit = (acc_reg < NY);
            sgdc_pkg::C_ACC_LE_YD:  cond_hit = (acc_reg <= ydays_x);
            sgdc_pkg::C_S_STOP:     cond_hit = (idx_reg == 4'(sgdc_pkg::LAST_MONTH))
                                               || (acc_reg < len_s_x);
            sgdc_pkg::C_G_STOP:     cond_hit = (idx_reg == 4'(sgdc_pkg::LAST_MONTH))
                                               || g_fit;
            default:                cond_hit = 1'b0;
        endcase
    end

    assign exec   = !(cond_hit && ctrl.gate);
    assign finish = (state_reg == sgdc_pkg::ST_RUN) && exec
                    && ((ctrl.op == sgdc_pkg::OP_DONE_S) || (ctrl.op == sgdc_pkg::OP_DONE_G)
                        || (ctrl.op == sgdc_pkg::OP_REJECT));
    assign stall  = finish && out_valid_reg && !answer.ready;

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        kind_next      = kind_reg;
        year_next      = year_reg;
        month_next     = month_reg;
        day_next       = day_reg;
        acc_next       = acc_reg;
        idx_next       = idx_reg;
        ry_next        = ry_reg;
        lyear_next     = lyear_reg;
        doy_next       = doy_reg;
        out_valid_next = out_valid_reg && !answer.ready;
        oyear_next     = oyear_reg;
        omonth_next    = omonth_reg;
        oday_next      = oday_reg;
        odoy_next      = odoy_reg;
        oerr_next      = oerr_reg;

        unique case (state_reg)
            sgdc_pkg::ST_IDLE:
            begin
                if (query.valid)
                begin
                    kind_next  = query.kind;
                    year_next  = query.year_in;
                    month_next = query.month_in;
                    day_next   = query.day_in;
                    pc_next    = sgdc_pkg::PC_ENTRY;
                    state_next = sgdc_pkg::ST_RUN;
                end
            end
            sgdc_pkg::ST_RUN:
            begin
                if (!stall)
                begin
                    if (cond_hit)
                    begin
                        pc_next = ctrl.target;
                    end
                    else if (!ctrl.hold)
                    begin
                        pc_next = pc_reg + 5'd1;
                    end

                    if (exec)
                    begin
                        unique case (ctrl.op)
                            sgdc_pkg::OP_NOP:
                            begin
                            end
                            sgdc_pkg::OP_INIT_G:
                            begin
                                acc_next   = signed'({5'b0, day_reg});
                                idx_next   = '0;
                                lyear_next = signed'({2'b0, year_reg});
                                ry_next    = signed'({2'b0, year_reg})
                                             - 16'(sgdc_pkg::SAKA_OFFSET);
                            end
                            sgdc_pkg::OP_INIT_S:
                            begin
                                acc_next   = signed'({5'b0, day_reg}) + (NY - 10'sd1);
                                idx_next   = '0;
                                ry_next    = signed'({2'b0, year_reg})
                                             + 16'(sgdc_pkg::SAKA_OFFSET);
                                lyear_next = signed'({2'b0, year_reg})
                                             + 16'(sgdc_pkg::SAKA_OFFSET);
                            end
                            sgdc_pkg::OP_ADD_GLEN:
                            begin
                                acc_next = acc_reg + len_g_x;
                                idx_next = idx_reg + 4'd1;
                            end
                            sgdc_pkg::OP_ADD_SLEN:
                            begin
                                acc_next = acc_reg + len_s_x;
                                idx_next = idx_reg + 4'd1;
                            end
                            sgdc_pkg::OP_SUB_GLEN:
                            begin
                                acc_next = acc_reg - len_g_x;
                                idx_next = idx_reg + 4'd1;
                            end
                            sgdc_pkg::OP_SUB_SLEN:
                            begin
                                acc_next = acc_reg - len_s_x;
                                idx_next = idx_reg + 4'd1;
                            end
                            sgdc_pkg::OP_SUB_NY:
                            begin
                                acc_next = acc_reg - NY;
                            end
                            sgdc_pkg::OP_PREV_YEAR:
                            begin
                                acc_next   = acc_reg - NY;
                                ry_next    = ry_reg - 16'sd1;
                                lyear_next = lyear_reg - 16'sd1;
                            end
                            sgdc_pkg::OP_ADD_YDAYS:
                            begin
                                acc_next = acc_reg + ydays_x;
                            end
                            sgdc_pkg::OP_WRAP:
                            begin
                                acc_next   = acc_reg - ydays_x;
                                ry_next    = ry_reg + 16'sd1;
                                lyear_next = lyear_reg + 16'sd1;
                            end
                            sgdc_pkg::OP_MARK_S:
                            begin
                                doy_next = acc_inc[8:0];
                                idx_next = '0;
                            end
                            sgdc_pkg::OP_MARK_G:
                            begin
                                doy_next = acc_reg[8:0];
                                idx_next = '0;
                            end
                            sgdc_pkg::OP_DONE_S:
                            begin
                                oyear_next  = ry_reg;
                                omonth_next = idx_reg;
                                oday_next   = acc_inc[4:0];
                                odoy_next   = doy_reg;
                                oerr_next   = 1'b0;
                            end
                            sgdc_pkg::OP_DONE_G:
                            begin
                                oyear_next = ry_reg;
                                oerr_next  = 1'b0;
                                if (g_fit)
                                begin
                                    omonth_next = idx_reg;
                                    oday_next   = acc_reg[4:0];
                                    odoy_next   = doy_reg;
                                end
                                else
                                begin
                                    omonth_next = 4'(sgdc_pkg::LAST_MONTH);
                                    oday_next   = 5'(sgdc_pkg::LONG_MONTH);
                                    odoy_next   = ydays;
                                end
                            end
                            sgdc_pkg::OP_REJECT:
                            begin
                                oyear_next  = signed'({2'b0, year_reg});
                                omonth_next = month_reg;
                                oday_next   = day_reg;
                                odoy_next   = '0;
                                oerr_next   = 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                    end

                    if (finish)
                    begin
                        out_valid_next = 1'b1;
                        state_next     = sgdc_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sgdc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sgdc_pkg::ST_IDLE;
            pc_reg        <= sgdc_pkg::PC_ENTRY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        year_reg   <= year_next;
        month_reg  <= month_next;
        day_reg    <= day_next;
        acc_reg    <= acc_next;
        idx_reg    <= idx_next;
        ry_reg     <= ry_next;
        lyear_reg  <= lyear_next;
        doy_reg    <= doy_next;
        oyear_reg  <= oyear_next;
        omonth_reg <= omonth_next;
        oday_reg   <= oday_next;
        odoy_reg   <= odoy_next;
        oerr_reg   <= oerr_next;
    end

    assign query.ready            = (state_reg == sgdc_pkg::ST_IDLE);
    assign answer.valid           = out_valid_reg;
    assign answer.year_out        = oyear_reg;
    assign answer.month_out       = omonth_reg;
    assign answer.day_out         = oday_reg;
    assign answer.day_of_year_out = odoy_reg;
    assign answer.error           = oerr_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sgdc_pkg::ST_RUN) |-> (pc_reg <= sgdc_pkg::PC_REJECT))
        else $error("sequencer left the microcode program");

    assert property (@(posedge clk) disable iff (!rst_n)
        (query.valid && query.ready) |=>
            (state_reg == sgdc_pkg::ST_RUN) && (pc_reg == sgdc_pkg::PC_ENTRY))
        else $error("accepted transaction did not start the program");

    assert property (@(posedge clk) disable iff (!rst_n)
        (finish && !stall) |=> answer.valid)
        else $error("finished conversion not presented");

    assert property (@(posedge clk) disable iff (!rst_n)
        (answer.valid && answer.error) |-> (answer.day_of_year_out == '0))
        else $error("rejected date carries a day of year");

endmodule

`default_nettype wire
